// File: rtl/core/water_level_from_adc_average_core_macros.svh
// Assertion macros for the water level core and its checker.
// Depends on nothing; take in with `include by bare file name.
`ifndef WATER_LEVEL_FROM_ADC_AVERAGE_CORE_MACROS_SVH
`define WATER_LEVEL_FROM_ADC_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define WLAVG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("water level core: property failed");

// Next-cycle implication, gated by the active-low reset.
`define WLAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("water level core: property failed");

`endif

// File: rtl/core/wlavg_pkg.sv
// Shared types, widths and constants of the water level core.
// Used by wlavg_ctrl, wlavg_dp, the top level and the checker.
package wlavg_pkg;

    localparam int CODE_W     = 10;
    localparam int SENSOR_W   = 3;
    localparam int REG_IDX_W  = 3;
    localparam int QUO_W      = 16;
    localparam int SQ_X_W     = 20;
    localparam int ROOT_W     = 10;
    localparam int SQ_REM_W   = 11;
    localparam int DIV_STEPS  = 16;
    localparam int SQRT_STEPS = 10;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int SAMPLES_PER_AVERAGE_DEF = 3;

    // Sensors 1 .. SENSOR_REFS own a reference; all others share the default.
    localparam int SENSOR_REFS = 4;
    localparam int REF_REGS    = SENSOR_REFS + 1;
    localparam int REF_DEF_IDX = SENSOR_REFS;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_REF_S1  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REF_S2  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REF_S3  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REF_S4  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REF_DEF = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BASE    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TOL     = 3'd6;

    localparam logic [CODE_W-1:0] RST_REF_S1  = 10'd579;
    localparam logic [CODE_W-1:0] RST_REF_S2  = 10'd559;
    localparam logic [CODE_W-1:0] RST_REF_S3  = 10'd561;
    localparam logic [CODE_W-1:0] RST_REF_S4  = 10'd561;
    localparam logic [CODE_W-1:0] RST_REF_DEF = 10'd573;
    localparam logic [CODE_W-1:0] RST_BASE    = 10'd102;
    localparam logic [CODE_W-1:0] RST_TOL     = 10'd102;

    localparam logic [CODE_W-1:0] LEVEL_FULL  = 10'd1000;
    localparam logic [SQ_X_W-1:0] LEVEL_SCALE = 20'd1000000;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_num;
        logic [CODE_W-1:0]   sample;
    } t_in_req;

    typedef struct packed {
        logic [SENSOR_W-1:0] out_sensor;
        logic [CODE_W-1:0]   average_code;
        logic [CODE_W-1:0]   level_tenths;
    } t_out_req;

    typedef struct packed {
        logic run_acc;
        logic div_load_avg;
        logic div_load_ratio;
        logic div_step;
        logic avg_latch;
        logic level_fixed;
        logic sqrt_load;
        logic sqrt_step;
        logic level_root;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic run_done;
        logic level_full;
        logic level_empty;
        logic out_busy;
    } t_sts;

endpackage

// File: rtl/core/wlavg_ctrl.sv
// Sequencer of the water level core: state machine and step counter.
// Depends on wlavg_pkg; drives wlavg_dp through t_cmd, watches t_sts.
module wlavg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wlavg_pkg::t_sts   i_sts,
    output wlavg_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_AVG    = 4'd1;
    localparam logic [3:0] ST_LATCH  = 4'd2;
    localparam logic [3:0] ST_DECIDE = 4'd3;
    localparam logic [3:0] ST_RATIO  = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_SQRT   = 4'd6;
    localparam logic [3:0] ST_ROOT   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    localparam logic [wlavg_pkg::STEP_W-1:0] DIV_LAST  =
        wlavg_pkg::STEP_W'(wlavg_pkg::DIV_STEPS - 1);
    localparam logic [wlavg_pkg::STEP_W-1:0] SQRT_LAST =
        wlavg_pkg::STEP_W'(wlavg_pkg::SQRT_STEPS - 1);

    logic [3:0]                    r_state, n_state;
    logic [wlavg_pkg::STEP_W-1:0]  r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.run_acc = 1'b1;
                    if (i_sts.run_done) begin
                        o_cmd.div_load_avg = 1'b1;
                        n_step             = '0;
                        n_state            = ST_AVG;
                    end
                end
            end
            ST_AVG: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    n_step  = '0;
                    n_state = ST_LATCH;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_LATCH: begin
                o_cmd.avg_latch = 1'b1;
                n_state         = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.level_full || i_sts.level_empty) begin
                    o_cmd.level_fixed = 1'b1;
                    n_state           = ST_OUT;
                end else begin
                    o_cmd.div_load_ratio = 1'b1;
                    n_step               = '0;
                    n_state              = ST_RATIO;
                end
            end
            ST_RATIO: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    n_step  = '0;
                    n_state = ST_MUL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.sqrt_load = 1'b1;
                n_step          = '0;
                n_state         = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == SQRT_LAST) begin
                    n_step  = '0;
                    n_state = ST_ROOT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_ROOT: begin
                o_cmd.level_root = 1'b1;
                n_state          = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// File: rtl/core/wlavg_dp.sv
// Datapath of the water level core: run accumulator, settings registers,
// shared restoring divider, level multiplier, digit-wise square root, output.
// Depends on wlavg_pkg; steered by wlavg_ctrl.
module wlavg_dp #(
    parameter int SAMPLES_PER_AVERAGE = wlavg_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wlavg_pkg::t_cmd                     i_cmd,
    output wlavg_pkg::t_sts                     o_sts,
    input  wlavg_pkg::t_in_req                  i_in_req,
    input  logic                                i_cfg_wr_en,
    input  logic [wlavg_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [wlavg_pkg::CODE_W-1:0]        i_cfg_wdata,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output wlavg_pkg::t_out_req                 o_out_req
);

    localparam int CW    = wlavg_pkg::CODE_W;
    localparam int SUM_W = CW + $clog2(SAMPLES_PER_AVERAGE);
    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int QW    = wlavg_pkg::QUO_W;
    localparam int XW    = wlavg_pkg::SQ_X_W;
    localparam int RW    = wlavg_pkg::ROOT_W;
    localparam int SRW   = wlavg_pkg::SQ_REM_W;
    localparam int PW    = QW + XW;

    // settings
    logic [CW-1:0] r_ref [wlavg_pkg::REF_REGS];
    logic [CW-1:0] r_base, r_tol;

    // run accumulator
    logic [SUM_W-1:0]                  r_sum;
    logic [CNT_W-1:0]                  r_count;
    logic [wlavg_pkg::SENSOR_W-1:0]    r_run_sensor;

    // result working set
    logic [wlavg_pkg::SENSOR_W-1:0]    r_sensor;
    logic [CW-1:0]                     r_avg, r_level;
    logic [CW-1:0]                     r_rem, r_div;
    logic [QW-1:0]                     r_quo;
    logic [XW-1:0]                     r_sq_x;
    logic [SRW-1:0]                    r_sq_rem;
    logic [RW-1:0]                     r_root;
    logic                              r_out_valid;
    wlavg_pkg::t_out_req               r_out;

    logic                              restart;
    logic [SUM_W-1:0]                  n_sum;
    logic [CNT_W-1:0]                  n_count;
    logic [2:0]                        ref_idx;
    logic [CW-1:0]                     ref_sel;
    logic [CW:0]                       div_trial;
    logic                              div_fit;
    logic [CW-1:0]                     n_rem;
    logic [QW-1:0]                     n_quo;
    logic [PW-1:0]                     prod;
    logic [SRW+1:0]                    sq_t;
    logic [RW+1:0]                     sq_trial;
    logic                              sq_fit;
    logic [SRW-1:0]                    n_sq_rem;
    logic [RW-1:0]                     n_root;

    // run update: a sample from another sensor drops the partial run
    assign restart = (r_count != '0) && (i_in_req.sensor_num != r_run_sensor);
    assign n_sum   = (restart ? '0 : r_sum) + SUM_W'(i_in_req.sample);
    assign n_count = (restart ? '0 : r_count) + 1'b1;

    // reference of the run's sensor
    always_comb begin
        if ((r_sensor != '0) && (32'(r_sensor) <= wlavg_pkg::SENSOR_REFS)) begin
            ref_idx = 3'(r_sensor - 1'b1);
        end else begin
            ref_idx = 3'(wlavg_pkg::REF_DEF_IDX);
        end
        ref_sel = r_ref[ref_idx];
    end

    // restoring divider step: one quotient bit a cycle
    assign div_trial = {r_rem, r_quo[QW-1]};
    assign div_fit   = div_trial >= {1'b0, r_div};
    assign n_rem     = div_fit ? CW'(div_trial - {1'b0, r_div}) : div_trial[CW-1:0];
    assign n_quo     = {r_quo[QW-2:0], div_fit};

    // ratio scaled to millionths, then Q16 dropped
    assign prod = PW'(r_quo) * PW'(wlavg_pkg::LEVEL_SCALE);

    // square root step: one root bit from two radicand bits
    assign sq_t     = {r_sq_rem, r_sq_x[XW-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_fit   = sq_t >= {1'b0, sq_trial};
    assign n_sq_rem = sq_fit ? SRW'(sq_t - {1'b0, sq_trial}) : sq_t[SRW-1:0];
    assign n_root   = {r_root[RW-2:0], sq_fit};

    assign o_sts.run_done    = (n_count == CNT_W'(SAMPLES_PER_AVERAGE));
    assign o_sts.level_full  = ({1'b0, r_avg} + {1'b0, r_tol}) >= {1'b0, ref_sel};
    assign o_sts.level_empty = r_avg <= r_base;
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // control state and settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref[0]     <= wlavg_pkg::RST_REF_S1;
            r_ref[1]     <= wlavg_pkg::RST_REF_S2;
            r_ref[2]     <= wlavg_pkg::RST_REF_S3;
            r_ref[3]     <= wlavg_pkg::RST_REF_S4;
            r_ref[4]     <= wlavg_pkg::RST_REF_DEF;
            r_base       <= wlavg_pkg::RST_BASE;
            r_tol        <= wlavg_pkg::RST_TOL;
            r_sum        <= '0;
            r_count      <= '0;
            r_run_sensor <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    wlavg_pkg::REG_REF_S1:  r_ref[0] <= i_cfg_wdata;
                    wlavg_pkg::REG_REF_S2:  r_ref[1] <= i_cfg_wdata;
                    wlavg_pkg::REG_REF_S3:  r_ref[2] <= i_cfg_wdata;
                    wlavg_pkg::REG_REF_S4:  r_ref[3] <= i_cfg_wdata;
                    wlavg_pkg::REG_REF_DEF: r_ref[4] <= i_cfg_wdata;
                    wlavg_pkg::REG_BASE:    r_base   <= i_cfg_wdata;
                    wlavg_pkg::REG_TOL:     r_tol    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.run_acc) begin
                r_run_sensor <= i_in_req.sensor_num;
                if (o_sts.run_done) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load_avg) begin
            r_sensor <= i_in_req.sensor_num;
            r_rem    <= '0;
            r_quo    <= QW'(n_sum);
            r_div    <= CW'(SAMPLES_PER_AVERAGE);
        end else if (i_cmd.div_load_ratio) begin
            r_rem <= r_avg - r_base;
            r_quo <= '0;
            r_div <= ref_sel - r_base;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.avg_latch) begin
            r_avg <= r_quo[CW-1:0];
        end
        if (i_cmd.sqrt_load) begin
            r_sq_x   <= prod[PW-1 -: XW];
            r_sq_rem <= '0;
            r_root   <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_x   <= {r_sq_x[XW-3:0], 2'b00};
            r_sq_rem <= n_sq_rem;
            r_root   <= n_root;
        end
        if (i_cmd.level_fixed) begin
            r_level <= o_sts.level_full ? wlavg_pkg::LEVEL_FULL : '0;
        end else if (i_cmd.level_root) begin
            r_level <= (r_root > wlavg_pkg::LEVEL_FULL) ? wlavg_pkg::LEVEL_FULL : r_root;
        end
        if (i_cmd.out_load) begin
            r_out.out_sensor   <= r_sensor;
            r_out.average_code <= r_avg;
            r_out.level_tenths <= r_level;
        end
    end

endmodule

// File: rtl/core/water_level_from_adc_average_core.sv
// Water level core, top level: joins the sequencer and the datapath.
// Depends on wlavg_pkg, wlavg_ctrl and wlavg_dp.
//
// Use:
//   Input channel (i_in_valid / o_in_ready / i_in_req) takes one ADC sample
//   request tagged with its sensor number. Runs of SAMPLES_PER_AVERAGE samples
//   from one sensor are summed; a sample from another sensor restarts the run.
//   Output channel (o_out_valid / i_out_ready / o_out_req) gives one request
//   per completed run: sensor, truncated average and level in 0.1 % steps.
//   Settings are written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata
//   by the user only while the core is idle; the block does not enforce it;
//   indexes beyond the tolerance register drop.
// Sequence: a sample that does not complete a run is only summed; a completing
//   one holds o_in_ready low while the 16-step divider forms the average. The
//   average is latched, then either a fixed level is set (full or empty) or a
//   further 16-step ratio divide, a multiply and a 10-step square root run.
//   When the output register is free the result loads and o_in_ready rises.
//   The output register decouples the sides: samples keep flowing while a
//   result waits; a stalled receiver blocks only the next completed run.
// Reset: clears the run, the output valid and restores default settings.
module water_level_from_adc_average_core #(
    parameter int SAMPLES_PER_AVERAGE = wlavg_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  wlavg_pkg::t_in_req              i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output wlavg_pkg::t_out_req             o_out_req,
    input  logic                            i_cfg_wr_en,
    input  logic [wlavg_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [wlavg_pkg::CODE_W-1:0]    i_cfg_wdata
);

    wlavg_pkg::t_cmd cmd;
    wlavg_pkg::t_sts sts;

    // sequence the work of one completed run
    wlavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // accumulate, divide, take the root and hold the result
    wlavg_dp #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_req    (i_in_req),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

// File: rtl/core/wlavg_checker.sv
// Port-level checker of the water level core, bound to the top level.
// Depends on wlavg_pkg and water_level_from_adc_average_core_macros.svh.
`include "water_level_from_adc_average_core_macros.svh"

module wlavg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input wlavg_pkg::t_out_req             o_out_req
);

    // level never exceeds full scale
    `WLAVG_ASSERT_NOW(a_level_range, i_clk, i_rst_n, o_out_valid, o_out_req.level_tenths <= wlavg_pkg::LEVEL_FULL)

    // a stalled result holds
    `WLAVG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_req))

    // ready drops only after a sample request was taken
    `WLAVG_ASSERT_NOW(a_ready_drop, i_clk, i_rst_n, $fell(o_in_ready), $past(i_in_valid))

    // a fresh result is never loaded in a cycle that took a sample
    `WLAVG_ASSERT_NOW(a_result_gap, i_clk, i_rst_n, $rose(o_out_valid), !$past(i_in_valid && o_in_ready))

endmodule

bind water_level_from_adc_average_core wlavg_checker u_checker (.*);
